### rtl/sem_pkg.sv
// Shared types and constants for the Sobel edge magnitude block.
// Used by the top, front and back modules under rtl/; depends on nothing else.
`default_nettype none
package sem_pkg;

    localparam int DIM_W       = 13;      // width for width/height compares
    localparam int ROW_W       = 12;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 13;
    localparam int ROOT_STEPS  = 11;      // 22-bit radicand, one result bit a step
    localparam logic [DIM_W-1:0] HEIGHT_LIMIT = 13'd4096;
    localparam logic [7:0] EDGE_MAX = 8'd255;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_index_t;

    typedef enum logic {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

    // [2] red, [1] green, [0] blue
    typedef logic [2:0][7:0] pixel_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } item_t;

    typedef struct packed {
        logic [7:0] edge_red;
        logic [7:0] edge_green;
        logic [7:0] edge_blue;
        logic       frame_end;
    } result_t;

    typedef struct packed {
        logic top_border;
        logic bottom_border;
        logic left_border;
        logic right_border;
        logic frame_end;
    } job_flags_t;

    // window indexed [row][column], centre at [1][1]
    typedef struct packed {
        pixel_t [2:0][2:0] win;
        job_flags_t        flags;
    } job_t;

endpackage
`default_nettype wire

### rtl/sobel_edge_magnitude_top.sv
// Top level of the Sobel edge magnitude block: front, job queue, back, result queue.
// Depends on sem_pkg, sem_fifo, sem_front and sem_back.
`default_nettype none
// RGB pixels enter in raster order on a queue-style port (push/full) and
// per-channel Sobel magnitudes leave on another (empty/pop), one row and one
// pixel behind; flush items (kind 1) move the tail of a frame out. The front
// does a line-store read on transfer, then the write-back and window shift,
// held while a result's job meets a full job queue. Each result then passes
// the back part (sums, squares, 11 steps of the bit-serial square root and
// hand-off), which takes a new job only after its hand-off; items without a
// result skip it. The user writes frame width and height through the
// cfg_valid/cfg_ready port only while the block is idle; it is not enforced.
module sobel_edge_magnitude_top #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  sem_pkg::item_t                     item,
    output logic                               full,
    output logic                               empty,
    input  wire logic                          pop,
    output sem_pkg::result_t                   result,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data
);

    sem_pkg::job_t    job_in, job_out;
    sem_pkg::result_t res_in;
    logic             job_push, job_full, job_pop, job_empty;
    logic             res_push, res_full;

    assign cfg_ready = 1'b1;

    sem_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .item      (item),
        .full      (full),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .job_full  (job_full),
        .job_push  (job_push),
        .job       (job_in)
    );

    sem_fifo #(.DATA_T(sem_pkg::job_t)) u_job_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data (job_in),
        .full    (job_full),
        .rd_en   (job_pop),
        .rd_data (job_out),
        .empty   (job_empty)
    );

    sem_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (job_empty),
        .job       (job_out),
        .job_pop   (job_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_in)
    );

    sem_fifo #(.DATA_T(sem_pkg::result_t)) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_in),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule
`default_nettype wire

### rtl/sem_fifo.sv
// Two-entry queue of any packed type.
// Used between the front and back parts and on the result side; no package use.
`default_nettype none
module sem_fifo #(
    parameter type DATA_T = logic
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  wr_en,
    input  DATA_T      wr_data,
    output logic       full,
    input  wire logic  rd_en,
    output DATA_T      rd_data,
    output logic       empty
);

    DATA_T      mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] count_reg, count_next;
    logic       do_wr, do_rd;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_wr)
            begin
                wptr_reg <= !wptr_reg;
            end
            if (do_rd)
            begin
                rptr_reg <= !rptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wptr_reg] <= wr_data;
        end
    end

endmodule
`default_nettype wire

### rtl/sem_front.sv
// Front part: configuration registers, line stores, 3x3 window and frame position.
// Depends on sem_pkg; emits one window job per result into the job queue.
`default_nettype none
module sem_front #(
    parameter int MAX_WIDTH = 1024
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  sem_pkg::item_t                     item,
    output logic                               full,
    input  wire logic                          cfg_valid,
    input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sem_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                          job_full,
    output logic                               job_push,
    output sem_pkg::job_t                      job
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam logic [sem_pkg::DIM_W-1:0] WMAX = sem_pkg::DIM_W'(MAX_WIDTH);

    typedef enum logic [1:0] {
        F_IDLE = 2'b01,
        F_EXEC = 2'b10
    } fstate_t;

    fstate_t                      state_reg, state_next;
    logic [10:0]                  fw_reg;
    logic [12:0]                  fh_reg;
    sem_pkg::item_t               item_reg;
    logic [CW-1:0]                slot_reg;
    logic [CW:0]                  fill_reg;
    logic [CW-1:0]                ocol_reg;
    logic [sem_pkg::ROW_W-1:0]    orow_reg;
    sem_pkg::pixel_t [2:0][2:0]   win_reg;
    sem_pkg::pixel_t [2:0][2:0]   win_next;
    logic [2:0]                   cv_reg;

    sem_pkg::pixel_t              upper_mem [MAX_WIDTH];
    logic [24:0]                  middle_mem [MAX_WIDTH];
    sem_pkg::pixel_t              up_rd_reg;
    logic [24:0]                  mid_rd_reg;

    logic [sem_pkg::DIM_W-1:0]    w_used, h_used, fw_ext, slot_inc, ocol_inc, orow_inc;
    logic                         accept, commit, filled, is_pixel, mid_valid, hit;
    sem_pkg::pixel_t              up_col, mid_col, pix;
    logic                         right_b, bottom_b;

    assign full     = (state_reg != F_IDLE);
    assign accept   = push && (state_reg == F_IDLE);
    assign is_pixel = (item_reg.kind == sem_pkg::KIND_PIXEL);
    assign pix      = is_pixel ? {item_reg.pixel_red, item_reg.pixel_green,
                                  item_reg.pixel_blue} : '0;
    assign filled   = ({1'b0, slot_reg} < fill_reg);
    assign up_col   = filled ? up_rd_reg : '0;
    assign mid_col  = filled ? mid_rd_reg[23:0] : '0;
    assign mid_valid = filled && mid_rd_reg[24];
    assign hit      = cv_reg[2];   // becomes the centre valid bit after the shift
    assign commit   = (state_reg == F_EXEC) && (!hit || !job_full);
    assign job_push = (state_reg == F_EXEC) && hit && !job_full;

    assign fw_ext = {2'b00, fw_reg};
    always_comb
    begin
        if (fw_reg == 11'd0)
        begin
            w_used = sem_pkg::DIM_W'(1);
        end
        else if (fw_ext > WMAX)
        begin
            w_used = WMAX;
        end
        else
        begin
            w_used = fw_ext;
        end
        if (fh_reg == 13'd0)
        begin
            h_used = sem_pkg::DIM_W'(1);
        end
        else if (fh_reg > sem_pkg::HEIGHT_LIMIT)
        begin
            h_used = sem_pkg::HEIGHT_LIMIT;
        end
        else
        begin
            h_used = fh_reg;
        end
    end

    assign slot_inc = sem_pkg::DIM_W'(slot_reg) + sem_pkg::DIM_W'(1);
    assign ocol_inc = sem_pkg::DIM_W'(ocol_reg) + sem_pkg::DIM_W'(1);
    assign orow_inc = sem_pkg::DIM_W'(orow_reg) + sem_pkg::DIM_W'(1);
    assign right_b  = (ocol_inc >= w_used);
    assign bottom_b = (orow_inc >= h_used);

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_next[r][0] = win_reg[r][1];
            win_next[r][1] = win_reg[r][2];
        end
        win_next[0][2] = up_col;
        win_next[1][2] = mid_col;
        win_next[2][2] = pix;
    end

    always_comb
    begin
        job.win                 = win_next;
        job.flags.top_border    = (orow_reg == '0);
        job.flags.bottom_border = bottom_b;
        job.flags.left_border   = (ocol_reg == '0);
        job.flags.right_border  = right_b;
        job.flags.frame_end     = right_b && bottom_b;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_EXEC;
                end
            end
            F_EXEC:
            begin
                if (commit)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            fw_reg    <= 11'd1024;
            fh_reg    <= 13'd1024;
            slot_reg  <= '0;
            fill_reg  <= '0;
            ocol_reg  <= '0;
            orow_reg  <= '0;
            win_reg   <= '0;
            cv_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    sem_pkg::CFG_FRAME_WIDTH:  fw_reg <= cfg_data[10:0];
                    sem_pkg::CFG_FRAME_HEIGHT: fh_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (commit)
            begin
                win_reg   <= win_next;
                cv_reg[0] <= cv_reg[1];
                cv_reg[1] <= cv_reg[2];
                cv_reg[2] <= mid_valid;
                slot_reg  <= (slot_inc >= w_used) ? '0 : CW'(slot_inc);
                if (fill_reg == {1'b0, slot_reg})
                begin
                    fill_reg <= fill_reg + {{CW{1'b0}}, 1'b1};
                end
                if (hit)
                begin
                    if (right_b)
                    begin
                        ocol_reg <= '0;
                        orow_reg <= bottom_b ? '0 : sem_pkg::ROW_W'(orow_inc);
                    end
                    else
                    begin
                        ocol_reg <= CW'(ocol_inc);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item;
        end
    end

    // line stores: read on transfer, written back when the item commits
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            up_rd_reg <= upper_mem[slot_reg];
        end
        if (commit)
        begin
            upper_mem[slot_reg] <= mid_col;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mid_rd_reg <= middle_mem[slot_reg];
        end
        if (commit)
        begin
            middle_mem[slot_reg] <= {is_pixel, pix};
        end
    end

endmodule
`default_nettype wire

### rtl/sem_back.sv
// Back part: Sobel sums, squares and a bit-serial square root per channel.
// Depends on sem_pkg; takes jobs from the job queue, pushes results.
`default_nettype none
module sem_back (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        job_empty,
    input  sem_pkg::job_t    job,
    output logic             job_pop,
    input  wire logic        res_full,
    output logic             res_push,
    output sem_pkg::result_t res
);

    typedef enum logic [4:0] {
        B_IDLE   = 5'b00001,
        B_SUM    = 5'b00010,
        B_SQUARE = 5'b00100,
        B_ROOT   = 5'b01000,
        B_DONE   = 5'b10000
    } bstate_t;

    bstate_t         state_reg, state_next;
    sem_pkg::job_t   job_reg;
    logic [3:0]      step_reg;
    logic [9:0]      ax_reg [3];
    logic [9:0]      ay_reg [3];
    logic [21:0]     s_reg [3];
    logic [12:0]     rem_reg [3];
    logic [10:0]     root_reg [3];

    logic            keep [3][3];
    logic [9:0]      ax_c [3];
    logic [9:0]      ay_c [3];
    logic [12:0]     rem_c [3];
    logic [10:0]     root_c [3];
    logic [7:0]      mag_c [3];

    assign job_pop  = (state_reg == B_IDLE) && !job_empty;
    assign res_push = (state_reg == B_DONE) && !res_full;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int k = 0; k < 3; k++)
            begin
                keep[r][k] = !((r == 0) && job_reg.flags.top_border)
                          && !((r == 2) && job_reg.flags.bottom_border)
                          && !((k == 0) && job_reg.flags.left_border)
                          && !((k == 2) && job_reg.flags.right_border);
            end
        end
    end

    always_comb
    begin
        logic [9:0] v [3][3];
        logic [9:0] px, nx, py, ny;
        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    v[r][k] = keep[r][k] ? {2'b00, job_reg.win[r][k][ch]} : 10'd0;
                end
            end
            px = v[0][2] + {v[1][2][8:0], 1'b0} + v[2][2];
            nx = v[0][0] + {v[1][0][8:0], 1'b0} + v[2][0];
            py = v[2][0] + {v[2][1][8:0], 1'b0} + v[2][2];
            ny = v[0][0] + {v[0][1][8:0], 1'b0} + v[0][2];
            ax_c[ch] = (px >= nx) ? px - nx : nx - px;
            ay_c[ch] = (py >= ny) ? py - ny : ny - py;
        end
    end

    // one result bit a step: trial = 4*root + 1 against the shifted remainder
    always_comb
    begin
        logic [14:0] rem_sh, trial;
        for (int ch = 0; ch < 3; ch++)
        begin
            rem_sh = {rem_reg[ch], s_reg[ch][21:20]};
            trial  = {2'b00, root_reg[ch], 2'b01};
            if (rem_sh >= trial)
            begin
                rem_c[ch]  = 13'(rem_sh - trial);
                root_c[ch] = {root_reg[ch][9:0], 1'b1};
            end
            else
            begin
                rem_c[ch]  = 13'(rem_sh);
                root_c[ch] = {root_reg[ch][9:0], 1'b0};
            end
        end
    end

    always_comb
    begin
        logic [11:0] rounded;
        for (int ch = 0; ch < 3; ch++)
        begin
            rounded = {1'b0, root_reg[ch]}
                    + {11'd0, ({1'b0, root_reg[ch]} < {1'b0, rem_reg[ch][11:0]})
                              || rem_reg[ch][12]};
            mag_c[ch] = (rounded > 12'(sem_pkg::EDGE_MAX)) ? sem_pkg::EDGE_MAX
                                                           : rounded[7:0];
        end
    end

    always_comb
    begin
        res.edge_red   = mag_c[2];
        res.edge_green = mag_c[1];
        res.edge_blue  = mag_c[0];
        res.frame_end  = job_reg.flags.frame_end;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:   if (!job_empty) state_next = B_SUM;
            B_SUM:    state_next = B_SQUARE;
            B_SQUARE: state_next = B_ROOT;
            B_ROOT:   if (step_reg == 4'(sem_pkg::ROOT_STEPS - 1)) state_next = B_DONE;
            B_DONE:   if (!res_full) state_next = B_IDLE;
            default:  state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == B_ROOT)
            begin
                step_reg <= step_reg + 4'd1;
            end
            else
            begin
                step_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            job_reg <= job;
        end
        for (int ch = 0; ch < 3; ch++)
        begin
            if (state_reg == B_SUM)
            begin
                ax_reg[ch] <= ax_c[ch];
                ay_reg[ch] <= ay_c[ch];
            end
            if (state_reg == B_SQUARE)
            begin
                s_reg[ch]    <= (22'(ax_reg[ch]) * 22'(ax_reg[ch]))
                              + (22'(ay_reg[ch]) * 22'(ay_reg[ch]));
                rem_reg[ch]  <= '0;
                root_reg[ch] <= '0;
            end
            if (state_reg == B_ROOT)
            begin
                s_reg[ch]    <= {s_reg[ch][19:0], 2'b00};
                rem_reg[ch]  <= rem_c[ch];
                root_reg[ch] <= root_c[ch];
            end
        end
    end

endmodule
`default_nettype wire
